@@ rtl/pcm_pkg.sv @@
// Package for the 4x4 pixel color matrix: widths, register indexes,
// payload structs and divider stage types. No dependencies.
`timescale 1ns / 1ps
package pcm_pkg;

  localparam int NumCh    = 4;
  localparam int SrcW     = 17;  // byte + signed 16-bit pre-bias
  localparam int ProdW    = 33;  // 17 x 16 signed product
  localparam int AccW     = 36;  // four products plus signed 32-bit post-bias
  localparam int RemW     = AccW - 1;
  localparam int DivW     = 31;
  localparam int DivSteps = 8;
  localparam int CmpW     = DivW + DivSteps;

  localparam logic [7:0] ClampMax = 8'd255;

  localparam logic [2:0] RegCoef0   = 3'd0;
  localparam logic [2:0] RegCoef1   = 3'd1;
  localparam logic [2:0] RegCoef2   = 3'd2;
  localparam logic [2:0] RegCoef3   = 3'd3;
  localparam logic [2:0] RegInBias  = 3'd4;
  localparam logic [2:0] RegOBiasLo = 3'd5;
  localparam logic [2:0] RegOBiasHi = 3'd6;
  localparam logic [2:0] RegDivisor = 3'd7;

  typedef struct packed {
    logic [7:0] in_byte0;
    logic [7:0] in_byte1;
    logic [7:0] in_byte2;
    logic [7:0] in_byte3;
    logic       frame_end;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic       frame_end_out;
  } pix_out_t;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [7:0]      quo;
    logic            clip_lo;
    logic            clip_hi;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NumCh-1:0] lane;
    logic                  frame_end;
  } div_stage_t;

endpackage

@@ rtl/pcm_div_step.sv @@
// One restoring-division stage: resolves one quotient bit for all four lanes.
// Depends on pcm_pkg.
`timescale 1ns / 1ps
module pcm_div_step import pcm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic             in_vld,
  input  div_stage_t       in_stage,
  input  logic [DivW-1:0]  divisor,
  input  logic [2:0]       bit_idx,
  output logic             vld_r,
  output div_stage_t       stage_r
);

  logic [CmpW-1:0] dshift;
  div_stage_t      stage_nxt;
  logic            vld_nxt;

  assign dshift  = {{DivSteps{1'b0}}, divisor} << bit_idx;
  assign vld_nxt = in_vld;

  always_comb begin
    stage_nxt = in_stage;
    for (int i = 0; i < NumCh; i++) begin
      if ({{(CmpW-RemW){1'b0}}, in_stage.lane[i].rem} >= dshift) begin
        stage_nxt.lane[i].rem = RemW'({{(CmpW-RemW){1'b0}}, in_stage.lane[i].rem} - dshift);
        stage_nxt.lane[i].quo = in_stage.lane[i].quo | (8'd1 << bit_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_vld) begin
      stage_r <= stage_nxt;
    end
  end

endmodule

@@ rtl/pixel_color_matrix_4x4_core.sv @@
// 4x4 pixel color matrix with pre-bias, post-bias, divide and clamp.
// Throughput one pixel per cycle while the consumer keeps out_ready high.
// Stages: pre-bias, multiply, sum, range check, 8 divider bit stages.
// Each stage stalls only when the stage after it is full and stalled.
// Reset (rst_n, synchronous): pipeline empty, registers to identity matrix,
// zero biases and divisor one. Depends on pcm_pkg and pcm_div_step.
`timescale 1ns / 1ps
module pixel_color_matrix_4x4_core import pcm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pix_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pix_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int NumStg = 4 + DivSteps;

  // ---------------- configuration registers ----------------
  logic [63:0]     coef_r [NumCh];
  logic [63:0]     ibias_r;
  logic [63:0]     obias_lo_r;
  logic [63:0]     obias_hi_r;
  logic [DivW-1:0] div_r;
  logic [DivW-1:0] div_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0]  <= 64'h0000_0000_0000_0001;
      coef_r[1]  <= 64'h0000_0000_0001_0000;
      coef_r[2]  <= 64'h0000_0001_0000_0000;
      coef_r[3]  <= 64'h0001_0000_0000_0000;
      ibias_r    <= '0;
      obias_lo_r <= '0;
      obias_hi_r <= '0;
      div_r      <= DivW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        RegCoef0:   coef_r[0]  <= cfg_data;
        RegCoef1:   coef_r[1]  <= cfg_data;
        RegCoef2:   coef_r[2]  <= cfg_data;
        RegCoef3:   coef_r[3]  <= cfg_data;
        RegInBias:  ibias_r    <= cfg_data;
        RegOBiasLo: obias_lo_r <= cfg_data;
        RegOBiasHi: obias_hi_r <= cfg_data;
        RegDivisor: div_r      <= cfg_data[DivW-1:0];
        default:    ;
      endcase
    end
  end

  // A zero divisor behaves as one.
  assign div_eff = (div_r == '0) ? DivW'(1) : div_r;

  // ---------------- flow control ----------------
  // A stage loads when it is empty or its successor loads; the output stage
  // loads when the consumer takes the transaction.
  logic [NumStg:1]   vld;
  logic [NumStg+1:1] ld;

  always_comb begin
    ld[NumStg+1] = out_ready;
    for (int k = NumStg; k >= 1; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign in_ready = ld[1];

  // ---------------- stage 1: widen and pre-bias ----------------
  logic signed [SrcW-1:0] src_r [NumCh];
  logic signed [SrcW-1:0] src_nxt [NumCh];
  logic                   fe1_r;
  logic [7:0]             in_bytes [NumCh];

  assign in_bytes[0] = in_data.in_byte0;
  assign in_bytes[1] = in_data.in_byte1;
  assign in_bytes[2] = in_data.in_byte2;
  assign in_bytes[3] = in_data.in_byte3;

  always_comb begin
    for (int j = 0; j < NumCh; j++) begin
      src_nxt[j] = $signed({9'd0, in_bytes[j]})
                 + $signed({ibias_r[16*j+15], ibias_r[16*j +: 16]});
    end
  end

  // ---------------- stage 2: sixteen products ----------------
  logic signed [ProdW-1:0] prod_r [NumCh][NumCh];
  logic signed [ProdW-1:0] prod_nxt [NumCh][NumCh];
  logic                    fe2_r;

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      for (int j = 0; j < NumCh; j++) begin
        prod_nxt[i][j] = src_r[j] * $signed(coef_r[i][16*j +: 16]);
      end
    end
  end

  // ---------------- stage 3: sum with post-bias ----------------
  logic signed [AccW-1:0] acc_r [NumCh];
  logic signed [AccW-1:0] acc_nxt [NumCh];
  logic [31:0]            post [NumCh];
  logic                   fe3_r;

  assign post[0] = obias_lo_r[31:0];
  assign post[1] = obias_lo_r[63:32];
  assign post[2] = obias_hi_r[31:0];
  assign post[3] = obias_hi_r[63:32];

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      acc_nxt[i] = $signed({{(AccW-32){post[i][31]}}, post[i]});
      for (int j = 0; j < NumCh; j++) begin
        acc_nxt[i] = acc_nxt[i]
                   + $signed({{(AccW-ProdW){prod_r[i][j][ProdW-1]}}, prod_r[i][j]});
      end
    end
  end

  // ---------------- stage 4: range check ----------------
  // Non-positive sums clamp to zero; sums at or above 256 * divisor clamp
  // to full scale. Everything else goes through the divider.
  div_stage_t ck_r;
  div_stage_t ck_nxt;

  always_comb begin
    ck_nxt.frame_end = fe3_r;
    for (int i = 0; i < NumCh; i++) begin
      ck_nxt.lane[i].rem     = acc_r[i][RemW-1:0];
      ck_nxt.lane[i].quo     = '0;
      ck_nxt.lane[i].clip_lo = acc_r[i][AccW-1] || (acc_r[i] == '0);
      ck_nxt.lane[i].clip_hi = !ck_nxt.lane[i].clip_lo &&
          ({{(CmpW-RemW){1'b0}}, acc_r[i][RemW-1:0]} >= {div_eff, {DivSteps{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld[1] <= 1'b0;
      vld[2] <= 1'b0;
      vld[3] <= 1'b0;
      vld[4] <= 1'b0;
    end else begin
      if (ld[1]) vld[1] <= in_valid;
      if (ld[2]) vld[2] <= vld[1];
      if (ld[3]) vld[3] <= vld[2];
      if (ld[4]) vld[4] <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1] && in_valid) begin
      src_r <= src_nxt;
      fe1_r <= in_data.frame_end;
    end
    if (ld[2] && vld[1]) begin
      prod_r <= prod_nxt;
      fe2_r  <= fe1_r;
    end
    if (ld[3] && vld[2]) begin
      acc_r <= acc_nxt;
      fe3_r <= fe2_r;
    end
    if (ld[4] && vld[3]) begin
      ck_r <= ck_nxt;
    end
  end

  // ---------------- stages 5..12: one quotient bit each, MSB first ----------
  div_stage_t dstg [DivSteps+1];
  logic       dvld [DivSteps+1];

  assign dstg[0] = ck_r;
  assign dvld[0] = vld[4];

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    pcm_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (ld[5+k]),
      .in_vld   (dvld[k]),
      .in_stage (dstg[k]),
      .divisor  (div_eff),
      .bit_idx  (3'(DivSteps-1-k)),
      .vld_r    (dvld[k+1]),
      .stage_r  (dstg[k+1])
    );
    assign vld[5+k] = dvld[k+1];
  end

  // ---------------- output: clamp ----------------
  logic [7:0] ob [NumCh];

  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      if (dstg[DivSteps].lane[i].clip_lo) begin
        ob[i] = '0;
      end else if (dstg[DivSteps].lane[i].clip_hi) begin
        ob[i] = ClampMax;
      end else begin
        ob[i] = dstg[DivSteps].lane[i].quo;
      end
    end
  end

  assign out_valid              = vld[NumStg];
  assign out_data.out_byte0     = ob[0];
  assign out_data.out_byte1     = ob[1];
  assign out_data.out_byte2     = ob[2];
  assign out_data.out_byte3     = ob[3];
  assign out_data.frame_end_out = dstg[DivSteps].frame_end;

  // ---------------- assertions ----------------
  // An empty output stage never blocks the input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // Both clamp flags on one lane would mean the range check is broken.
  a_clip_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    vld[4] |-> !((ck_r.lane[0].clip_lo && ck_r.lane[0].clip_hi) ||
                 (ck_r.lane[1].clip_lo && ck_r.lane[1].clip_hi) ||
                 (ck_r.lane[2].clip_lo && ck_r.lane[2].clip_hi) ||
                 (ck_r.lane[3].clip_lo && ck_r.lane[3].clip_hi)))
    else $error("lane flagged both low and high clamp");

  // A stalled output transaction must still be there next cycle.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction lost or changed");

  // Lane 0's remainder entering the divider lies below 256 * divisor when not clamped.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld[4] && !ck_r.lane[0].clip_lo && !ck_r.lane[0].clip_hi |->
      ({{(CmpW-RemW){1'b0}}, ck_r.lane[0].rem} < {div_eff, {DivSteps{1'b0}}}))
    else $error("divider input out of range");

endmodule
